@@ rtl/core/assert_macros.svh @@
// Assertion helpers, clocked on clk_i with async reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/spr_pkg.sv @@
package spr_pkg;

  localparam int NumRegions = 16;
  localparam int IdxW       = (NumRegions > 1) ? $clog2(NumRegions) : 1;
  localparam int CntW       = $clog2(NumRegions + 1);

  localparam int PageW  = 20;
  localparam int SpanW  = 21;
  localparam int SumW   = 22;
  localparam int ProtW  = 3;
  localparam int AttrW  = 4;
  localparam int OpW    = 3;
  localparam int StatW  = 2;
  localparam int CfgIdxW = 1;

  localparam logic [SumW-1:0]  PageSpan    = SumW'(1) << PageW;
  localparam logic [SpanW-1:0] UserLowRst  = SpanW'(1024);
  localparam logic [SpanW-1:0] UserHighRst = SpanW'(786432);

  localparam logic [CfgIdxW-1:0] CfgUserLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgUserHigh = 1'b1;

  typedef enum logic [OpW-1:0] {
    OpInsert = 3'd0,
    OpLookup = 3'd1,
    OpFind   = 3'd2,
    OpCheck  = 3'd3,
    OpClear  = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StOverlap  = 2'd1,
    StFull     = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SShRd,
    SShWr,
    SWrNew,
    SDone
  } state_e;

  typedef struct packed {
    logic [PageW-1:0] start;
    logic [SpanW-1:0] endp;
    logic [AttrW-1:0] attr;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [PageW-1:0] start;
    logic [SpanW-1:0] count;
    logic             hifirst;
    logic [AttrW-1:0] attr;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [SpanW-1:0] page;
    logic [SpanW-1:0] endp;
    logic [ProtW-1:0] prot;
    logic             shared;
    logic             free;
  } res_t;

  typedef struct packed {
    logic            idle;
    logic [CntW-1:0] count;
  } core_stat_t;

endpackage

@@ rtl/core/spr_ram.sv @@
module spr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/spr_core.sv @@
module spr_core import spr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cmd_t             cmd_i,
  input  logic [SpanW-1:0] user_low_i,
  input  logic [SpanW-1:0] user_high_i,
  input  logic             out_free_i,
  output logic             res_vld_o,
  output res_t             res_o,
  output core_stat_t       stat_o
);

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [CntW-1:0]  cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d, j_q, j_d;
  logic             rdv_q, rdv_d, ovl_q, ovl_d, hit_q, hit_d, full_q;
  entry_t           hent_q, hent_d;
  logic [SpanW-1:0] prev_end_q, prev_end_d, ffirst_q, ffirst_d, flast_q, flast_d;
  logic             prev_vld_q, prev_vld_d, ffv_q, ffv_d, flv_q, flv_d;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  entry_t           wdata, ent;
  logic [EntryW-1:0] rdata;

  logic [SumW-1:0]  end_sum;
  logic             bad_ins, ent_ovl, ent_hit, fits, scan_done, ins_go;
  logic [SpanW-1:0] lo, hi;
  logic [CntW-1:0]  jm1;

  spr_ram #(.Width(EntryW), .Depth(NumRegions)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent     = entry_t'(rdata);
  assign end_sum = {2'b00, cmd_q.start} + {1'b0, cmd_q.count};
  assign bad_ins = (cmd_q.count == '0) || (end_sum > PageSpan);
  assign ent_ovl = ({2'b00, ent.start} < end_sum) && ({1'b0, cmd_q.start} < ent.endp);
  assign ent_hit = (cmd_q.start >= ent.start) && ({1'b0, cmd_q.start} < ent.endp);
  assign jm1     = j_q - CntW'(1);

  always_comb begin
    lo = user_low_i;
    if (prev_vld_q && (prev_end_q > user_low_i)) begin
      lo = prev_end_q;
    end
    hi = user_high_i;
    if ((state_q == SScan) && ({1'b0, ent.start} < user_high_i)) begin
      hi = {1'b0, ent.start};
    end
    fits = (hi > lo) && ((hi - lo) >= cmd_q.count);
  end

  assign scan_done = (idx_q == cnt_q) && !rdv_q;
  assign ins_go    = (cmd_q.op == OpInsert) && !bad_ins && !ovl_q && !full_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = ((cmd_i.op == OpClear) || (cmd_i.op > OpClear)) ? SDone : SScan;
        end
      end
      SScan: begin
        if (scan_done) begin
          if (ins_go) begin
            state_d = (cnt_q > pos_q) ? SShRd : SWrNew;
          end else begin
            state_d = SDone;
          end
        end
      end
      SShRd:  state_d = SShWr;
      SShWr:  state_d = (jm1 > pos_q) ? SShRd : SWrNew;
      SWrNew: state_d = SDone;
      SDone:  state_d = out_free_i ? SIdle : SDone;
      default: state_d = SIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    j_d        = j_q;
    rdv_d      = 1'b0;
    ovl_d      = ovl_q;
    hit_d      = hit_q;
    hent_d     = hent_q;
    prev_end_d = prev_end_q;
    prev_vld_d = prev_vld_q;
    ffirst_d   = ffirst_q;
    ffv_d      = ffv_q;
    flast_d    = flast_q;
    flv_d      = flv_q;
    we         = 1'b0;
    waddr      = j_q[IdxW-1:0];
    wdata      = ent;
    raddr      = idx_q[IdxW-1:0];
    res_vld_o  = 1'b0;
    res_o      = '0;
    res_o.status = StNotFound;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          idx_d      = '0;
          pos_d      = '0;
          j_d        = cnt_q;
          ovl_d      = 1'b0;
          hit_d      = 1'b0;
          prev_vld_d = 1'b0;
          ffv_d      = 1'b0;
          flv_d      = 1'b0;
          if (cmd_i.op == OpClear) begin
            cnt_d = '0;
          end
        end
      end
      SScan: begin
        if (idx_q < cnt_q) begin
          idx_d = idx_q + CntW'(1);
          rdv_d = 1'b1;
        end
        if (rdv_q) begin
          if (ent_ovl) begin
            ovl_d = 1'b1;
          end
          if (ent_hit) begin
            hit_d  = 1'b1;
            hent_d = ent;
          end
          if (ent.start < cmd_q.start) begin
            pos_d = pos_q + CntW'(1);
          end
          if (fits) begin
            flv_d   = 1'b1;
            flast_d = lo;
            if (!ffv_q) begin
              ffv_d    = 1'b1;
              ffirst_d = lo;
            end
          end
          prev_vld_d = 1'b1;
          prev_end_d = ent.endp;
        end
      end
      SShRd: begin
        raddr = jm1[IdxW-1:0];
      end
      SShWr: begin
        we  = 1'b1;
        j_d = jm1;
      end
      SWrNew: begin
        we    = 1'b1;
        waddr = pos_q[IdxW-1:0];
        wdata = '{start: cmd_q.start, endp: end_sum[SpanW-1:0], attr: cmd_q.attr};
        cnt_d = cnt_q + CntW'(1);
      end
      SDone: begin
        res_vld_o = out_free_i;
        unique case (cmd_q.op)
          OpInsert: begin
            if (bad_ins || ovl_q) begin
              res_o.status = StOverlap;
            end else if (full_q) begin
              res_o.status = StFull;
            end else begin
              res_o.status = StOk;
            end
          end
          OpLookup: begin
            if (hit_q) begin
              res_o.status = StOk;
              res_o.page   = {1'b0, hent_q.start};
              res_o.endp   = hent_q.endp;
              res_o.prot   = hent_q.attr[ProtW-1:0];
              res_o.shared = hent_q.attr[AttrW-1];
            end
          end
          OpFind: begin
            if (cmd_q.count != '0) begin
              if (cmd_q.hifirst) begin
                if (fits) begin
                  res_o.status = StOk;
                  res_o.page   = lo;
                end else if (flv_q) begin
                  res_o.status = StOk;
                  res_o.page   = flast_q;
                end
              end else begin
                if (ffv_q) begin
                  res_o.status = StOk;
                  res_o.page   = ffirst_q;
                end else if (fits) begin
                  res_o.status = StOk;
                  res_o.page   = lo;
                end
              end
            end
          end
          OpCheck: begin
            res_o.status = StOk;
            res_o.free   = (cmd_q.count == '0) || !ovl_q;
          end
          OpClear: res_o.status = StOk;
          default: res_o.status = StNotFound;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rdv_q   <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == SIdle)) begin
      cmd_q  <= cmd_i;
      full_q <= (cnt_q >= CntW'(NumRegions));
    end
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    j_q        <= j_d;
    ovl_q      <= ovl_d;
    hit_q      <= hit_d;
    hent_q     <= hent_d;
    prev_end_q <= prev_end_d;
    prev_vld_q <= prev_vld_d;
    ffirst_q   <= ffirst_d;
    ffv_q      <= ffv_d;
    flast_q    <= flast_d;
    flv_q      <= flv_d;
  end

  assign stat_o.idle  = (state_q == SIdle);
  assign stat_o.count = cnt_q;

endmodule

@@ rtl/core/sorted_page_region_table.sv @@
// Sorted table of up to NumRegions page regions [start, end) with protection and
// shared bits, held in one single-port-write RAM. One operation is in flight at a
// time. Every operation except clear and unknown codes scans the stored regions,
// one RAM read per cycle; an accepted insert then moves each region above the
// insertion point up by one slot, reading it in SShRd and writing it in SShWr,
// and then writes the new entry in SWrNew. Clear and unknown codes go to SDone. The
// result sits in an output register, so the next operation may start while it
// waits to be taken. Configuration writes take effect at once and must be made
// while no operation is pending.
module sorted_page_region_table import spr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SpanW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [PageW-1:0]   start_page_i,
  input  logic [SpanW-1:0]   page_count_i,
  input  logic               search_high_first_i,
  input  logic [ProtW-1:0]   prot_bits_i,
  input  logic               shared_bit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatW-1:0]   status_o,
  output logic [SpanW-1:0]   page_result_o,
  output logic [SpanW-1:0]   end_result_o,
  output logic [ProtW-1:0]   hit_prot_o,
  output logic               hit_shared_o,
  output logic               range_free_o
);

`include "assert_macros.svh"

  logic [SpanW-1:0] user_low_q, user_high_q;
  logic             out_vld_q, out_free, res_vld, start;
  res_t             res, out_q;
  cmd_t             cmd;
  core_stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_low_q  <= UserLowRst;
      user_high_q <= UserHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgUserLow:  user_low_q  <= cfg_data_i;
        CfgUserHigh: user_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = stat.idle;
  assign start      = in_valid_i && stat.idle;
  assign out_free   = !out_vld_q || out_ready_i;

  assign cmd.op      = op_i;
  assign cmd.start   = start_page_i;
  assign cmd.count   = page_count_i;
  assign cmd.hifirst = search_high_first_i;
  assign cmd.attr    = {shared_bit_i, prot_bits_i};

  spr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .user_low_i  (user_low_q),
    .user_high_i (user_high_q),
    .out_free_i  (out_free),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .stat_o      (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign page_result_o = out_q.page;
  assign end_result_o  = out_q.endp;
  assign hit_prot_o    = out_q.prot;
  assign hit_shared_o  = out_q.shared;
  assign range_free_o  = out_q.free;

  `SPR_ASSERT_NOW(a_cnt_max, 1'b1, stat.count <= CntW'(NumRegions), "region count overflow")
  `SPR_ASSERT_NOW(a_res_slot, res_vld, out_free, "result overwrites pending output")
  `SPR_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, !in_ready_o, "accepted while busy")

endmodule
